@@ rtl/imat_pkg.sv @@
// ----------------------------------------------------------------------------
// imat_pkg
// Shared widths, command/status/register codes and control structs of the
// integer matrix add/subtract/multiply block.
// ----------------------------------------------------------------------------
package imat_pkg;

  localparam int CMD_W     = 2;
  localparam int ROW_W     = 3;
  localparam int COL_W     = 3;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 4;   // widest configuration register
  localparam int CFG_IDX_W = 3;
  localparam int DIM_W     = 4;   // holds a dimension 1..8
  localparam int OP_W      = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  // operations
  localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB     = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL     = 2'd2;
  localparam logic [OP_W-1:0] OP_INVALID = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] STAT_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DIM = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OP  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 3'd4;

  // tag that rides with each store read through the datapath
  typedef struct packed {
    logic valid;
    logic first;   // first term of an element: load the accumulator
    logic lastk;   // final term of an element: result is complete
  } rd_ctl_t;

  typedef struct packed {
    logic mul;
    logic sub;
  } op_ctl_t;

endpackage

@@ rtl/imat_if.sv @@
// ----------------------------------------------------------------------------
// imat_if
// Valid/ready channels for commands in and result elements out.
// ----------------------------------------------------------------------------
interface imat_in_if;
  import imat_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [ROW_W-1:0]         row;
  logic [COL_W-1:0]         col;
  logic signed [DATA_W-1:0] value;

  modport source(output valid, command, row, col, value, input ready);
  modport sink(input valid, command, row, col, value, output ready);
endinterface

interface imat_out_if;
  import imat_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [ROW_W-1:0]         out_row;
  logic [COL_W-1:0]         out_col;
  logic signed [DATA_W-1:0] result_value;
  logic                     last;

  modport source(output valid, status, out_row, out_col, result_value, last, input ready);
  modport sink(input valid, status, out_row, out_col, result_value, last, output ready);
endinterface

@@ rtl/imat_datapath.sv @@
// ----------------------------------------------------------------------------
// imat_datapath
// Stores A and B with registered reads, then one add/sub/multiply stage
// and an accumulator that sums the terms of one result element.
// ----------------------------------------------------------------------------
module imat_datapath #(
  parameter int  MAX_DIM = 8,
  localparam int DEPTH   = MAX_DIM * MAX_DIM,
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_a,
  input  logic                          wr_b,
  input  logic [AW-1:0]                 waddr,
  input  logic [imat_pkg::DATA_W-1:0]   wdata,
  input  imat_pkg::rd_ctl_t             rd_ctl,
  input  logic [AW-1:0]                 raddr_a,
  input  logic [AW-1:0]                 raddr_b,
  input  imat_pkg::op_ctl_t             op,
  output logic [imat_pkg::DATA_W-1:0]   acc,
  output logic                          done
);
  import imat_pkg::*;

  logic [DATA_W-1:0] mem_a [DEPTH];
  logic [DATA_W-1:0] mem_b [DEPTH];

  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;
  logic [DATA_W-1:0] term_r;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] acc_r;
  rd_ctl_t           s1_r;
  rd_ctl_t           s2_r;
  logic              done_r;

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[waddr] <= wdata;
    end
    rd_a_r <= mem_a[raddr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[waddr] <= wdata;
    end
    rd_b_r <= mem_b[raddr_b];
  end

  // low word of the product is the same for signed and unsigned operands
  assign prod = rd_a_r * rd_b_r;

  always_ff @(posedge clk) begin
    if (op.mul) begin
      term_r <= prod;
    end else if (op.sub) begin
      term_r <= rd_a_r - rd_b_r;
    end else begin
      term_r <= rd_a_r + rd_b_r;
    end
    if (s2_r.valid) begin
      acc_r <= s2_r.first ? term_r : acc_r + term_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      s2_r   <= '0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= rd_ctl;
      s2_r   <= s1_r;
      done_r <= s2_r.valid && s2_r.lastk;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

@@ rtl/integer_matrix_add_sub_mul.sv @@
// ----------------------------------------------------------------------------
// integer_matrix_add_sub_mul
// Loads two signed 32-bit matrices into on-chip stores and emits their sum,
// difference or product element by element in row-major order.
// ----------------------------------------------------------------------------
// A write command (A or B element) lands in its store at the edge that takes
// it; writes with row or col not below MAX_DIM are dropped.
// A compute command walks the result in row-major order with one element in
// flight: each element reads its terms one per cycle from the single read
// port of each store, then passes a read stage, an arithmetic stage and the
// accumulator; the next element waits while the sink stalls the output and
// the result holding register stays full.
// A bad operation code (checked first) or a shape mismatch yields a single
// error transfer with zero row, column and value and last set. Dimension
// registers of 0 count as 1 and values above MAX_DIM count as MAX_DIM.
// Commands are accepted again once the final element has left the result
// holding register; the output register lets it wait there for the sink.
// Reading an element that was never written returns undefined data.
// ----------------------------------------------------------------------------
module integer_matrix_add_sub_mul #(
  parameter int  MAX_DIM = 8,
  localparam int DEPTH   = MAX_DIM * MAX_DIM,
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int IW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  imat_in_if.sink                        in_ch,
  imat_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [imat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [imat_pkg::CFG_W-1:0]     cfg_data
);
  import imat_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  // configuration registers
  logic [DIM_W-1:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic [OP_W-1:0]  operation_r;

  // sequencer
  logic           state_r, state_nxt;
  logic [IW-1:0]  r_r, c_r, k_r;
  logic [IW-1:0]  nr_last_r, nc_last_r, k_last_r;
  logic           mul_r, sub_r;
  logic           pend_r;

  // result holding register (value lives in the accumulator for OK results)
  logic                res_valid_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [IW-1:0]       res_row_r, res_col_r;
  logic                res_last_r;

  // output register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ROW_W-1:0]    out_row_r;
  logic [COL_W-1:0]    out_col_r;
  logic [DATA_W-1:0]   out_value_r;
  logic                out_last_r;

  logic             in_fire, in_range, compute_fire;
  logic [DIM_W-1:0] ra, ca, rb, cb;
  logic             op_bad, dim_bad;
  logic             issue_go, issue_lastk, elem_last, res_take;
  logic [IW-1:0]    a_col, b_row;
  logic [AW-1:0]    waddr, raddr_a, raddr_b;
  rd_ctl_t          rd_ctl;
  op_ctl_t          op_ctl;
  logic [DATA_W-1:0] dp_acc;
  logic             dp_done;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(MAX_DIM);
    if (d == '0) begin
      return DIM_W'(1);
    end else if (d > lim) begin
      return lim;
    end else begin
      return d;
    end
  endfunction

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(1);
      cols_a_r    <= DIM_W'(1);
      rows_b_r    <= DIM_W'(1);
      cols_b_r    <= DIM_W'(1);
      operation_r <= OP_ADD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS_A:    rows_a_r    <= cfg_data;
        REG_COLS_A:    cols_a_r    <= cfg_data;
        REG_ROWS_B:    rows_b_r    <= cfg_data;
        REG_COLS_B:    cols_b_r    <= cfg_data;
        REG_OPERATION: operation_r <= cfg_data[OP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input
  assign in_ch.ready  = (state_r == S_IDLE) && !res_valid_r;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign compute_fire = in_fire && (in_ch.command == CMD_COMPUTE);

  // Drop writes outside the stored square.
  assign in_range = ({1'b0, in_ch.row} < DIM_W'(MAX_DIM)) &&
                    ({1'b0, in_ch.col} < DIM_W'(MAX_DIM));
  assign waddr    = AW'(AW'(in_ch.row) * AW'(MAX_DIM) + AW'(in_ch.col));

  assign ra = clamp_dim(rows_a_r);
  assign ca = clamp_dim(cols_a_r);
  assign rb = clamp_dim(rows_b_r);
  assign cb = clamp_dim(cols_b_r);

  assign op_bad  = (operation_r == OP_INVALID);
  assign dim_bad = (operation_r == OP_MUL) ? (ca != rb) : ((ra != rb) || (ca != cb));

  // ---------------------------------------------------------------- walk
  // One element at a time: issue its terms, then hold until the sum lands
  // in the holding register and that register has been emptied.
  assign issue_go    = (state_r == S_RUN) && !pend_r && !res_valid_r;
  assign issue_lastk = !mul_r || (k_r == k_last_r);
  assign elem_last   = (r_r == nr_last_r) && (c_r == nc_last_r);

  // multiply reads A[r][k] and B[k][c]; add/sub read both at [r][c]
  assign a_col   = mul_r ? k_r : c_r;
  assign b_row   = mul_r ? k_r : r_r;
  assign raddr_a = AW'(AW'(r_r) * AW'(MAX_DIM) + AW'(a_col));
  assign raddr_b = AW'(AW'(b_row) * AW'(MAX_DIM) + AW'(c_r));

  assign rd_ctl.valid = issue_go;
  assign rd_ctl.first = (k_r == '0);
  assign rd_ctl.lastk = issue_lastk;
  assign op_ctl.mul   = mul_r;
  assign op_ctl.sub   = sub_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (compute_fire && !op_bad && !dim_bad) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (dp_done && elem_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (compute_fire) begin
        r_r <= '0;
        c_r <= '0;
        k_r <= '0;
      end
      if (issue_go) begin
        if (issue_lastk) begin
          k_r    <= '0;
          pend_r <= 1'b1;
        end else begin
          k_r <= k_r + IW'(1);
        end
      end
      // advance to the next element once this one is complete
      if (dp_done) begin
        pend_r <= 1'b0;
        if (c_r == nc_last_r) begin
          c_r <= '0;
          r_r <= r_r + IW'(1);
        end else begin
          c_r <= c_r + IW'(1);
        end
      end
    end
  end

  // latch shape and operation for the run
  always_ff @(posedge clk) begin
    if (compute_fire) begin
      nr_last_r <= IW'(ra - DIM_W'(1));
      nc_last_r <= IW'(((operation_r == OP_MUL) ? cb : ca) - DIM_W'(1));
      k_last_r  <= IW'(ca - DIM_W'(1));
      mul_r     <= (operation_r == OP_MUL);
      sub_r     <= (operation_r == OP_SUB);
    end
  end

  imat_datapath #(
    .MAX_DIM(MAX_DIM)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_a   (in_fire && (in_ch.command == CMD_WRITE_A) && in_range),
    .wr_b   (in_fire && (in_ch.command == CMD_WRITE_B) && in_range),
    .waddr  (waddr),
    .wdata  (in_ch.value),
    .rd_ctl (rd_ctl),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .op     (op_ctl),
    .acc    (dp_acc),
    .done   (dp_done)
  );

  // ---------------------------------------------------------------- results
  assign res_take = res_valid_r && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      if (res_take) begin
        res_valid_r <= 1'b0;
      end
      if (dp_done || (compute_fire && (op_bad || dim_bad))) begin
        res_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_done) begin
      res_status_r <= STAT_OK;
      res_row_r    <= r_r;
      res_col_r    <= c_r;
      res_last_r   <= elem_last;
    end else if (compute_fire) begin
      res_status_r <= op_bad ? STAT_OP : STAT_DIM;
      res_row_r    <= '0;
      res_col_r    <= '0;
      res_last_r   <= 1'b1;
    end
  end

  // output register: hold while stalled, load when empty or draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_status_r <= res_status_r;
      out_row_r    <= ROW_W'(res_row_r);
      out_col_r    <= COL_W'(res_col_r);
      out_value_r  <= (res_status_r == STAT_OK) ? dp_acc : '0;
      out_last_r   <= res_last_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.out_row      = out_row_r;
  assign out_ch.out_col      = out_col_r;
  assign out_ch.result_value = $signed(out_value_r);
  assign out_ch.last         = out_last_r;

  // ---------------------------------------------------------------- checks
  // a finished element must never land on an occupied holding register
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    dp_done |-> !res_valid_r)
    else $error("element completed while holding register full");

  a_pend_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_RUN))
    else $error("element in flight outside a run");

  a_addsub_one_term: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RUN) && !mul_r) |-> (k_r == '0))
    else $error("term counter moved during add or subtract");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_OK)) |-> (out_last_r && (out_value_r == '0)))
    else $error("error transfer not marked last or carries data");

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Integer matrix add/subtract/multiply testbench
// Loads A and B element by element through the command channel, programs the
// shape and operation registers between phases, and checks every result
// element against an in-bench model of the stores and the arithmetic. A short
// directed sequence comes first, then random phases with random back pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import imat_pkg::*;

  localparam int SIDE        = 8;          // matrix side the block is built with
  localparam int ITEM_TARGET = 250;        // commands in the random phases
  localparam int QUIET_TAIL  = 40;         // final commands sent with no idling
  localparam int SETTLE      = 16;         // cycles to let an element finish
  localparam int LONG_STALL  = 300;        // receiver hold-off under pressure
  localparam int LIMIT       = 2_000_000;  // watchdog, in clock cycles

  // command code the block must ignore
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [DATA_W-1:0]   value;
    logic                last;
  } elem_t;

  // one line of the directed sequence: a register write or a command, with
  // the single result typed in where it is obvious
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    cmd_item_t            item;
    bit                   typed;
    logic [STATUS_W-1:0]  want_status;
    logic [DATA_W-1:0]    want_value;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  imat_in_if  in_ch();
  imat_out_if out_ch();

  integer_matrix_add_sub_mul dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Model state: both stores, which entries hold data, and the registers
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] mat_a [SIDE*SIDE];
  logic [DATA_W-1:0] mat_b [SIDE*SIDE];
  bit                known_a [SIDE*SIDE];
  bit                known_b [SIDE*SIDE];
  logic [CFG_W-1:0]  rows_a_cfg, cols_a_cfg, rows_b_cfg, cols_b_cfg;
  logic [OP_W-1:0]   op_cfg;

  elem_t     fresh[$];          // elements caused by the latest command
  elem_t     pending_elems[$];  // elements still owed by the block, oldest first
  plan_row_t plan[$];

  int unsigned mismatches   = 0;
  int unsigned elems_seen   = 0;
  int unsigned error_elems  = 0;
  int unsigned cmds_sent    = 0;
  int unsigned random_items = 0;
  int unsigned reg_writes   = 0;
  int unsigned cycle_count  = 0;
  bit          quiet        = 0;  // no idling on either side
  bit          stall_request = 0; // ask the receiver for one long hold-off

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Timeout after %0d cycles, %0d elements still owed",
               cycle_count, pending_elems.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Model of the block
  // --------------------------------------------------------------------------
  // A dimension register of 0 counts as 1, anything above the side as the side.
  function automatic int fit(input logic [CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > SIDE) return SIDE;
    return int'(d);
  endfunction

  // True when a compute under the current registers walks the stores.
  function automatic bit gives_data();
    if (op_cfg == OP_INVALID) return 0;
    if (op_cfg == OP_MUL) return fit(cols_a_cfg) == fit(rows_b_cfg);
    return fit(rows_a_cfg) == fit(rows_b_cfg) && fit(cols_a_cfg) == fit(cols_b_cfg);
  endfunction

  function automatic elem_t mk_elem(input logic [STATUS_W-1:0] st, input int r,
                                    input int c, input logic [DATA_W-1:0] v,
                                    input bit lst);
    elem_t e;
    e.status = st;
    e.row    = ROW_W'(r);
    e.col    = COL_W'(c);
    e.value  = v;
    e.last   = lst;
    return e;
  endfunction

  // Apply one accepted command to the model and leave its elements in fresh.
  function automatic void forecast_command(input cmd_item_t it);
    int nr, nc, ca;
    logic [DATA_W-1:0] acc;
    fresh.delete();
    case (it.command)
      CMD_WRITE_A: begin
        mat_a[{it.row, it.col}]   = it.value;
        known_a[{it.row, it.col}] = 1;
      end
      CMD_WRITE_B: begin
        mat_b[{it.row, it.col}]   = it.value;
        known_b[{it.row, it.col}] = 1;
      end
      CMD_COMPUTE: begin
        // a bad operation code wins over a shape mismatch
        if (op_cfg == OP_INVALID) begin
          fresh.push_back(mk_elem(STAT_OP, 0, 0, '0, 1));
        end else if (!gives_data()) begin
          fresh.push_back(mk_elem(STAT_DIM, 0, 0, '0, 1));
        end else begin
          ca = fit(cols_a_cfg);
          nr = fit(rows_a_cfg);
          nc = (op_cfg == OP_MUL) ? fit(cols_b_cfg) : ca;
          for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
              if (op_cfg == OP_ADD) begin
                acc = mat_a[r*SIDE+c] + mat_b[r*SIDE+c];
              end else if (op_cfg == OP_SUB) begin
                acc = mat_a[r*SIDE+c] - mat_b[r*SIDE+c];
              end else begin
                acc = '0;
                for (int k = 0; k < ca; k++) acc += mat_a[r*SIDE+k] * mat_b[k*SIDE+c];
              end
              fresh.push_back(mk_elem(STAT_OK, r, c, acc, r == nr-1 && c == nc-1));
            end
          end
        end
      end
      default: ;  // unused code: nothing happens
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: compare every transfer with the oldest owed element
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    elem_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      elems_seen++;
      if (out_ch.status != STAT_OK) error_elems++;
      if (pending_elems.size() == 0) begin
        $error("unexpected result: status %0d row %0d col %0d value %h last %0d",
               out_ch.status, out_ch.out_row, out_ch.out_col, out_ch.result_value,
               out_ch.last);
        mismatches++;
      end else begin
        want = pending_elems.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          mismatches++;
        end
        if (out_ch.out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_ch.out_row);
          mismatches++;
        end
        if (out_ch.out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_ch.out_col);
          mismatches++;
        end
        if (out_ch.result_value !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, out_ch.result_value);
          mismatches++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver pacing: random hold-off bursts, long runs of ready, one long
  // stall on request, and no hold-off at all once the run goes quiet
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      if (stall_request) begin
        stall_request = 0;
        out_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic cmd_item_t mk_item(input logic [CMD_W-1:0] cmd, input int r,
                                        input int c, input logic [DATA_W-1:0] v);
    cmd_item_t it;
    it.command = cmd;
    it.row     = ROW_W'(r);
    it.col     = COL_W'(c);
    it.value   = v;
    return it;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
    plan_row_t p;
    p = '{default: '0};
    p.is_reg  = 1;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  function automatic plan_row_t cmd_row(input logic [CMD_W-1:0] cmd, input int r,
                                        input int c, input logic [DATA_W-1:0] v);
    plan_row_t p;
    p = '{default: '0};
    p.item = mk_item(cmd, r, c, v);
    return p;
  endfunction

  // compute whose single result can be read off directly
  function automatic plan_row_t chk_row(input logic [STATUS_W-1:0] st,
                                        input logic [DATA_W-1:0] v);
    plan_row_t p;
    p = cmd_row(CMD_COMPUTE, 0, 0, '0);
    p.typed       = 1;
    p.want_status = st;
    p.want_value  = v;
    return p;
  endfunction

  // Element values lean on the corners of the signed range.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return DATA_W'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_dim();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return CFG_W'($urandom_range(1, 3));
    if (pick < 80) return CFG_W'($urandom_range(4, 7));
    if (pick < 88) return CFG_W'(SIDE);
    if (pick < 94) return '0;
    return CFG_W'($urandom_range(9, 15));
  endfunction

  // Offer one command, maybe after a random gap, hold it until the block
  // takes it, then update the model. valid stays high on return so that a
  // following command goes out back to back.
  task automatic transfer(input cmd_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= it.command;
    in_ch.row     <= it.row;
    in_ch.col     <= it.col;
    in_ch.value   <= it.value;
    do @(posedge clk); while (!in_ch.ready);
    cmds_sent++;
    forecast_command(it);
  endtask

  task automatic send_cmd(input cmd_item_t it);
    transfer(it);
    foreach (fresh[j]) pending_elems.push_back(fresh[j]);
    if (it.command != CMD_NONE) random_items++;
    if (random_items >= ITEM_TARGET - QUIET_TAIL) quiet = 1;
  endtask

  // Drain the block, let the last element clear the pipe, then write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      REG_ROWS_A:    rows_a_cfg = val;
      REG_COLS_A:    cols_a_cfg = val;
      REG_ROWS_B:    rows_b_cfg = val;
      REG_COLS_B:    cols_b_cfg = val;
      REG_OPERATION: op_cfg     = val[OP_W-1:0];
      default: ;
    endcase
  endtask

  // Write one element, mostly inside the current shape of its matrix.
  task automatic scatter_write();
    bit to_b;
    int nr, nc, r, c;
    to_b = $urandom_range(0, 1);
    nr   = to_b ? fit(rows_b_cfg) : fit(rows_a_cfg);
    nc   = to_b ? fit(cols_b_cfg) : fit(cols_a_cfg);
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, nr - 1);
      c = $urandom_range(0, nc - 1);
    end else begin
      r = $urandom_range(0, SIDE - 1);
      c = $urandom_range(0, SIDE - 1);
    end
    send_cmd(mk_item(to_b ? CMD_WRITE_B : CMD_WRITE_A, r, c, pick_value()));
  endtask

  // Load every entry the next compute reads that holds no data yet.
  task automatic fill_operands();
    for (int r = 0; r < fit(rows_a_cfg); r++)
      for (int c = 0; c < fit(cols_a_cfg); c++)
        if (!known_a[r*SIDE+c]) send_cmd(mk_item(CMD_WRITE_A, r, c, pick_value()));
    for (int r = 0; r < fit(rows_b_cfg); r++)
      for (int c = 0; c < fit(cols_b_cfg); c++)
        if (!known_b[r*SIDE+c]) send_cmd(mk_item(CMD_WRITE_B, r, c, pick_value()));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int n_comp;
    int phase;
    logic [CFG_W-1:0] ra, ca, rb, cb;
    logic [OP_W-1:0]  op;

    // drive every input to a known value while reset is held
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= '0;
    in_ch.row     <= '0;
    in_ch.col     <= '0;
    in_ch.value   <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    foreach (known_a[i]) begin
      known_a[i] = 0;
      known_b[i] = 0;
      mat_a[i]   = '0;
      mat_b[i]   = '0;
    end
    rows_a_cfg = 1;
    cols_a_cfg = 1;
    rows_b_cfg = 1;
    cols_b_cfg = 1;
    op_cfg     = OP_ADD;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Reset shapes are 1x1 with add selected; walk through
    // wrap-around in every operation, the ignored command code, bad operation
    // ahead of a bad shape, shape mismatch for add and multiply, and zero
    // dimension registers reading as one.
    plan.push_back(cmd_row(CMD_WRITE_A, 0, 0, 32'h7FFF_FFFF));
    plan.push_back(cmd_row(CMD_WRITE_B, 0, 0, 32'h0000_0001));
    plan.push_back(chk_row(STAT_OK, 32'h8000_0000));
    plan.push_back(reg_row(REG_OPERATION, CFG_W'(OP_SUB)));
    plan.push_back(cmd_row(CMD_WRITE_A, 0, 0, 32'h8000_0000));
    plan.push_back(chk_row(STAT_OK, 32'h7FFF_FFFF));
    plan.push_back(reg_row(REG_OPERATION, CFG_W'(OP_MUL)));
    plan.push_back(cmd_row(CMD_WRITE_B, 0, 0, 32'hFFFF_FFFF));
    plan.push_back(chk_row(STAT_OK, 32'h8000_0000));
    plan.push_back(cmd_row(CMD_NONE, 0, 0, 32'h0000_0005));
    plan.push_back(chk_row(STAT_OK, 32'h8000_0000));
    plan.push_back(reg_row(REG_OPERATION, CFG_W'(OP_INVALID)));
    plan.push_back(chk_row(STAT_OP, '0));
    plan.push_back(reg_row(REG_COLS_A, 4'd2));
    plan.push_back(chk_row(STAT_OP, '0));
    plan.push_back(reg_row(REG_OPERATION, CFG_W'(OP_ADD)));
    plan.push_back(chk_row(STAT_DIM, '0));
    plan.push_back(reg_row(REG_OPERATION, CFG_W'(OP_MUL)));
    plan.push_back(chk_row(STAT_DIM, '0));
    plan.push_back(reg_row(REG_OPERATION, CFG_W'(OP_ADD)));
    plan.push_back(reg_row(REG_ROWS_A, 4'd0));
    plan.push_back(reg_row(REG_COLS_A, 4'd0));
    plan.push_back(chk_row(STAT_OK, 32'h7FFF_FFFF));
    // 2x1 times 1x2 with the far corners of both stores touched as well
    plan.push_back(cmd_row(CMD_WRITE_A, 7, 7, 32'h1234_5678));
    plan.push_back(cmd_row(CMD_WRITE_B, 7, 7, 32'hEDCB_A987));
    plan.push_back(reg_row(REG_OPERATION, CFG_W'(OP_MUL)));
    plan.push_back(reg_row(REG_ROWS_A, 4'd2));
    plan.push_back(reg_row(REG_COLS_A, 4'd1));
    plan.push_back(reg_row(REG_COLS_B, 4'd2));
    plan.push_back(cmd_row(CMD_WRITE_A, 1, 0, 32'h0001_0003));
    plan.push_back(cmd_row(CMD_WRITE_B, 0, 1, 32'h7FFF_0001));
    plan.push_back(cmd_row(CMD_COMPUTE, 5, 2, 32'hDEAD_BEEF));

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        transfer(plan[i].item);
        if (plan[i].typed)
          pending_elems.push_back(mk_elem(plan[i].want_status, 0, 0, plan[i].want_value, 1));
        else
          foreach (fresh[j]) pending_elems.push_back(fresh[j]);
      end
    end

    // Random phases. Each one reprograms all five registers while the block
    // is drained, then runs a few load-and-compute rounds. Most shapes match
    // the operation so the stores get walked; the rest hit the error paths.
    phase = 0;
    while (random_items < ITEM_TARGET) begin
      ra = rand_dim();
      ca = rand_dim();
      op = ($urandom_range(0, 9) == 0) ? OP_INVALID : OP_W'($urandom_range(0, 2));
      if ($urandom_range(0, 4) != 0) begin
        if (op == OP_MUL) begin
          rb = ca;
          cb = rand_dim();
        end else begin
          rb = ra;
          cb = ca;
        end
      end else begin
        rb = rand_dim();
        cb = rand_dim();
      end
      // pin down the largest product once and a mid-size add for pressure
      if (phase == 1) begin
        ra = 4'd15; ca = CFG_W'(SIDE); rb = CFG_W'(SIDE); cb = 4'd15; op = OP_MUL;
      end else if (phase == 2) begin
        ra = 4'd4; ca = 4'd4; rb = 4'd4; cb = 4'd4; op = OP_ADD;
      end
      write_reg(REG_ROWS_A, ra);
      write_reg(REG_COLS_A, ca);
      write_reg(REG_ROWS_B, rb);
      write_reg(REG_COLS_B, cb);
      write_reg(REG_OPERATION, CFG_W'(op));

      n_comp = $urandom_range(1, 3);
      for (int j = 0; j < n_comp; j++) begin
        repeat ($urandom_range(0, 6)) scatter_write();
        if ($urandom_range(0, 9) == 0)
          send_cmd(mk_item(CMD_NONE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom));
        if (gives_data()) fill_operands();
        // hold the receiver off while this compute and the loads behind it
        // pile up against a stalled block
        if (phase == 2 && j == 0) stall_request = 1;
        send_cmd(mk_item(CMD_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom));
      end
      repeat ((phase == 2) ? 6 : $urandom_range(0, 3)) scatter_write();
      phase++;
    end

    // wait for every owed element, then a little longer for strays
    in_ch.valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (4 * SETTLE) @(posedge clk);

    $display("Covered %0d commands over %0d random phases and %0d register writes,",
             cmds_sent, phase, reg_writes);
    $display("checking %0d result elements, %0d of them error reports.",
             elems_seen, error_elems);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/imat_pkg.sv
rtl/imat_if.sv
rtl/imat_datapath.sv
rtl/integer_matrix_add_sub_mul.sv
verif/testbench.sv
